>>> sv/pwf_pkg.sv
package pwf_pkg;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned COUNT_WIDTH     = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // Event kinds.
   localparam logic [3:0] KIND_BOOT      = 4'd0;
   localparam logic [3:0] KIND_BEGIN     = 4'd1;
   localparam logic [3:0] KIND_AUTH      = 4'd2;
   localparam logic [3:0] KIND_ENROLL    = 4'd3;
   localparam logic [3:0] KIND_SUBMIT    = 4'd4;
   localparam logic [3:0] KIND_USABLE    = 4'd5;
   localparam logic [3:0] KIND_CONFIRM   = 4'd6;
   localparam logic [3:0] KIND_PROMOTE   = 4'd7;
   localparam logic [3:0] KIND_FAIL      = 4'd8;
   localparam logic [3:0] KIND_AUTHORIZE = 4'd9;
   localparam logic [3:0] KIND_CLOSE     = 4'd10;
   localparam logic [3:0] KIND_TICK      = 4'd11;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_DURATION   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HANDOVER_DURATION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN_DURATION = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_AUTH_FAILURES = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_SSID_BYTES    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_PASS_BYTES    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PASS_BYTES    = 3'd6;

   // Encoded mode values as they appear on the result channel.
   localparam logic [2:0] MODE_CODE_AWAIT    = 3'd0;
   localparam logic [2:0] MODE_CODE_OPER     = 3'd1;
   localparam logic [2:0] MODE_CODE_WINDOW   = 3'd2;
   localparam logic [2:0] MODE_CODE_PENDING  = 3'd3;
   localparam logic [2:0] MODE_CODE_HANDOVER = 3'd4;
   localparam logic [2:0] MODE_CODE_PROMOTE  = 3'd5;
   localparam logic [2:0] MODE_CODE_OFFLINE  = 3'd6;

   typedef enum logic [6:0] {
      MODE_AWAIT    = 7'b0000001,
      MODE_OPER     = 7'b0000010,
      MODE_WINDOW   = 7'b0000100,
      MODE_PENDING  = 7'b0001000,
      MODE_HANDOVER = 7'b0010000,
      MODE_PROMOTE  = 7'b0100000,
      MODE_OFFLINE  = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [3:0]            kind;
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  indicator;
      logic                  has_owner;
      logic                  ssid_present;
      logic [7:0]            ssid_length;
      logic                  pass_present;
      logic [7:0]            pass_length;
   } req_payload_type;

   typedef struct packed {
      logic                   accepted;
      logic [2:0]             mode;
      logic                   session_ok;
      logic                   owner_is_bound;
      logic                   creds_active;
      logic [COUNT_WIDTH-1:0] failure_total;
   } rsp_payload_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  window_duration_ms;
      logic [TIME_WIDTH-1:0]  handover_duration_ms;
      logic [TIME_WIDTH-1:0]  cooldown_duration_ms;
      logic [COUNT_WIDTH-1:0] max_auth_failures;
      logic [7:0]             max_ssid_bytes;
      logic [7:0]             min_pass_bytes;
      logic [7:0]             max_pass_bytes;
   } cfg_type;

   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] code;
      code = MODE_CODE_AWAIT;
      case (mode)
         MODE_AWAIT:    code = MODE_CODE_AWAIT;
         MODE_OPER:     code = MODE_CODE_OPER;
         MODE_WINDOW:   code = MODE_CODE_WINDOW;
         MODE_PENDING:  code = MODE_CODE_PENDING;
         MODE_HANDOVER: code = MODE_CODE_HANDOVER;
         MODE_PROMOTE:  code = MODE_CODE_PROMOTE;
         MODE_OFFLINE:  code = MODE_CODE_OFFLINE;
         default:       code = MODE_CODE_AWAIT;
      endcase
      return code;
   endfunction

endpackage

>>> sv/pwf_if.sv
interface pwf_req_if import pwf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pwf_rsp_if import pwf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> sv/provisioning_window_fsm.sv
// Provisioning window controller.
// Requests arrive on req_if (valid/ready); each carries one provisioning event
// and a wrapping millisecond time stamp. Every request yields exactly one
// response on rsp_if with the accepted flag and the resulting mode and flags.
// A request is taken into an input register; once the output register is free
// or drains, the event is applied to the mode register, flags, failure counter
// and time stamps and the response is written to the output register, at the
// same edge. One request can be taken every cycle while rsp_if.ready stays
// high; the state registers and the output register load at the same edge,
// which sets that rate.
// When the receiver holds rsp_if.ready low, the response stays put and one more
// request is parked in the input register; after that req_if.ready drops.
// Configuration registers are written through csr_we/csr_index/csr_wdata and
// should only change while no request is in flight.
// Synchronous reset clears both channel stages, the mode (awaiting activation),
// all flags, the failure count and the time stamps, and restores the register
// defaults.
module provisioning_window_fsm import pwf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   pwf_req_if.sink                    req_if,
   pwf_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type         cfg;
   logic            stage_valid_ff, stage_valid_in;
   req_payload_type stage_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type core_result;
   logic            advance;

   pwf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (stage_data_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // The parked request moves on whenever the output register is free or drains.
   assign advance       = stage_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !stage_valid_ff || advance;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_if.ready) begin
         stage_valid_in = req_if.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         stage_data_ff <= req_if.data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   a_reset_clears_rsp : assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

   a_advance_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_if.valid)
      else $error("applied request produced no response");

   a_stall_means_full : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (stage_valid_ff && rsp_if.valid && !rsp_if.ready))
      else $error("request side stalled without both stages full");

   a_session_in_window : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.session_ok) |-> (rsp_if.data.mode == MODE_CODE_WINDOW))
      else $error("session reported outside the window");

endmodule

>>> sv/pwf_csr.sv
module pwf_csr import pwf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_DURATION:   cfg_in.window_duration_ms   = csr_wdata[TIME_WIDTH-1:0];
            CSR_HANDOVER_DURATION: cfg_in.handover_duration_ms = csr_wdata[TIME_WIDTH-1:0];
            CSR_COOLDOWN_DURATION: cfg_in.cooldown_duration_ms = csr_wdata[TIME_WIDTH-1:0];
            CSR_MAX_AUTH_FAILURES: cfg_in.max_auth_failures    = csr_wdata[COUNT_WIDTH-1:0];
            CSR_MAX_SSID_BYTES:    cfg_in.max_ssid_bytes       = csr_wdata[7:0];
            CSR_MIN_PASS_BYTES:    cfg_in.min_pass_bytes       = csr_wdata[7:0];
            CSR_MAX_PASS_BYTES:    cfg_in.max_pass_bytes       = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_duration_ms   <= 32'd300000;
         cfg_ff.handover_duration_ms <= 32'd30000;
         cfg_ff.cooldown_duration_ms <= 32'd60000;
         cfg_ff.max_auth_failures    <= 8'd5;
         cfg_ff.max_ssid_bytes       <= 8'd32;
         cfg_ff.min_pass_bytes       <= 8'd8;
         cfg_ff.max_pass_bytes       <= 8'd63;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/pwf_core.sv
module pwf_core import pwf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type cmd,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   mode_type               mode_ff, mode_in;
   logic                   active_ff, active_in;
   logic                   owner_ff, owner_in;
   logic                   pending_ff, pending_in;
   logic                   session_ff, session_in;
   logic [COUNT_WIDTH-1:0] fail_count_ff, fail_count_in;
   logic [TIME_WIDTH-1:0]  window_start_ff, window_start_in;
   logic [TIME_WIDTH-1:0]  handover_start_ff, handover_start_in;
   logic [TIME_WIDTH-1:0]  cooldown_until_ff, cooldown_until_in;
   logic                   accepted;

   logic                   win;
   logic [TIME_WIDTH-1:0]  since_window;
   logic [TIME_WIDTH-1:0]  since_handover;
   logic [TIME_WIDTH-1:0]  since_cooldown;
   logic                   window_expired;
   logic                   handover_expired;
   logic                   in_cooldown;
   logic                   creds_ok;
   logic [COUNT_WIDTH-1:0] fail_bumped;

   assign win              = (mode_ff == MODE_WINDOW);
   assign since_window     = cmd.now_ms - window_start_ff;
   assign since_handover   = cmd.now_ms - handover_start_ff;
   assign since_cooldown   = cmd.now_ms - cooldown_until_ff;
   assign window_expired   = (since_window >= cfg.window_duration_ms);
   assign handover_expired = (since_handover >= cfg.handover_duration_ms);
   // Before the deadline when the wrapped difference is negative.
   assign in_cooldown      = (cooldown_until_ff != '0) && since_cooldown[TIME_WIDTH-1];
   assign creds_ok = cmd.ssid_present && (cmd.ssid_length != 8'd0)
                     && (cmd.ssid_length <= cfg.max_ssid_bytes)
                     && cmd.pass_present && (cmd.pass_length >= cfg.min_pass_bytes)
                     && (cmd.pass_length <= cfg.max_pass_bytes);
   assign fail_bumped = (fail_count_ff < cfg.max_auth_failures)
                        ? fail_count_ff + COUNT_WIDTH'(1) : fail_count_ff;

   always_comb begin
      mode_in           = mode_ff;
      active_in         = active_ff;
      owner_in          = owner_ff;
      pending_in        = pending_ff;
      session_in        = session_ff;
      fail_count_in     = fail_count_ff;
      window_start_in   = window_start_ff;
      handover_start_in = handover_start_ff;
      cooldown_until_in = cooldown_until_ff;
      accepted          = 1'b0;

      case (cmd.kind)
         KIND_BOOT: begin
            active_in  = cmd.indicator;
            owner_in   = cmd.has_owner;
            pending_in = 1'b0;
            session_in = 1'b0;
            mode_in    = cmd.indicator ? MODE_OPER : MODE_AWAIT;
            accepted   = 1'b1;
         end
         KIND_BEGIN: begin
            if ((mode_ff == MODE_AWAIT || mode_ff == MODE_OPER || mode_ff == MODE_OFFLINE)
                && !in_cooldown) begin
               window_start_in = cmd.now_ms;
               fail_count_in   = '0;
               pending_in      = 1'b0;
               session_in      = 1'b0;
               mode_in         = MODE_WINDOW;
               accepted        = 1'b1;
            end
         end
         KIND_AUTH: begin
            if (win) begin
               session_in = 1'b1;
               accepted   = 1'b1;
            end
         end
         KIND_ENROLL: begin
            if (win && session_ff && !owner_ff) begin
               owner_in = 1'b1;
               accepted = 1'b1;
            end
         end
         KIND_SUBMIT: begin
            if (win && session_ff && owner_ff && creds_ok) begin
               pending_in = 1'b1;
               mode_in    = MODE_PENDING;
               accepted   = 1'b1;
            end
         end
         KIND_USABLE: begin
            if (mode_ff == MODE_PENDING && pending_ff) begin
               handover_start_in = cmd.now_ms;
               mode_in           = MODE_HANDOVER;
               accepted          = 1'b1;
            end
         end
         KIND_CONFIRM: begin
            if (mode_ff == MODE_HANDOVER && !since_handover[TIME_WIDTH-1]
                && !handover_expired) begin
               mode_in  = MODE_PROMOTE;
               accepted = 1'b1;
            end
         end
         KIND_PROMOTE: begin
            if (mode_ff == MODE_PROMOTE && pending_ff) begin
               active_in  = 1'b1;
               pending_in = 1'b0;
               session_in = 1'b0;
               mode_in    = MODE_OPER;
               accepted   = 1'b1;
            end
         end
         KIND_FAIL: begin
            if (win) begin
               fail_count_in = fail_bumped;
               if (fail_bumped >= cfg.max_auth_failures) begin
                  cooldown_until_in = cmd.now_ms + cfg.cooldown_duration_ms;
                  session_in        = 1'b0;
                  mode_in           = active_ff ? MODE_OPER : MODE_AWAIT;
               end
               accepted = 1'b1;
            end
         end
         KIND_AUTHORIZE: begin
            accepted = win && session_ff && owner_ff && cmd.indicator;
         end
         KIND_CLOSE: begin
            pending_in = 1'b0;
            session_in = 1'b0;
            mode_in    = (cmd.indicator && active_ff) ? MODE_OPER : MODE_AWAIT;
            accepted   = 1'b1;
         end
         KIND_TICK: begin
            if ((win || mode_ff == MODE_PENDING || mode_ff == MODE_HANDOVER)
                && (window_expired || (mode_ff == MODE_HANDOVER && handover_expired))) begin
               pending_in = 1'b0;
               session_in = 1'b0;
               mode_in    = active_ff ? MODE_OPER : MODE_AWAIT;
            end
            accepted = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_AWAIT;
         active_ff         <= 1'b0;
         owner_ff          <= 1'b0;
         pending_ff        <= 1'b0;
         session_ff        <= 1'b0;
         fail_count_ff     <= '0;
         window_start_ff   <= '0;
         handover_start_ff <= '0;
         cooldown_until_ff <= '0;
      end else if (step) begin
         mode_ff           <= mode_in;
         active_ff         <= active_in;
         owner_ff          <= owner_in;
         pending_ff        <= pending_in;
         session_ff        <= session_in;
         fail_count_ff     <= fail_count_in;
         window_start_ff   <= window_start_in;
         handover_start_ff <= handover_start_in;
         cooldown_until_ff <= cooldown_until_in;
      end
   end

   always_comb begin
      result.accepted       = accepted;
      result.mode           = mode_code(mode_in);
      result.session_ok     = (mode_in == MODE_WINDOW) && session_in;
      result.owner_is_bound = owner_in;
      result.creds_active   = active_in;
      result.failure_total  = fail_count_in;
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pwf_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int PHASE_COUNT     = 6;
   localparam int FLOW_LENGTH     = 9;

   // Kind codes that the block does not decode.
   localparam logic [3:0] KIND_UNKNOWN_LO = 4'd12;
   localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;

   // Tracks the provisioning mode and flags and holds the status each request should produce.
   class window_status_board;
      cfg_type         cfg;
      logic [2:0]      mode;
      bit              creds_flag;
      bit              owner_flag;
      bit              pending_flag;
      bit              session_flag;
      logic [7:0]      fail_count;
      logic [31:0]     window_start;
      logic [31:0]     handover_start;
      logic [31:0]     cooldown_until;
      rsp_payload_type expected_status_q[$];
      int              errors;

      function new();
         cfg = '{32'd300000, 32'd30000, 32'd60000, 8'd5, 8'd32, 8'd8, 8'd63};
         mode = MODE_CODE_AWAIT;
         creds_flag = 0;
         owner_flag = 0;
         pending_flag = 0;
         session_flag = 0;
         fail_count = '0;
         window_start = '0;
         handover_start = '0;
         cooldown_until = '0;
         errors = 0;
      endfunction

      function void write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                   input logic [31:0] value);
         case (index)
            CSR_WINDOW_DURATION:   cfg.window_duration_ms = value;
            CSR_HANDOVER_DURATION: cfg.handover_duration_ms = value;
            CSR_COOLDOWN_DURATION: cfg.cooldown_duration_ms = value;
            CSR_MAX_AUTH_FAILURES: cfg.max_auth_failures = value[7:0];
            CSR_MAX_SSID_BYTES:    cfg.max_ssid_bytes = value[7:0];
            CSR_MIN_PASS_BYTES:    cfg.min_pass_bytes = value[7:0];
            CSR_MAX_PASS_BYTES:    cfg.max_pass_bytes = value[7:0];
            default: ;
         endcase
      endfunction

      // True when now lies before the deadline, judged on the wrapped difference.
      function bit before_deadline(input logic [31:0] now, input logic [31:0] deadline);
         logic [31:0] diff;
         diff = now - deadline;
         return diff[31];
      endfunction

      function bit elapsed(input logic [31:0] now, input logic [31:0] start,
                           input logic [31:0] span);
         logic [31:0] diff;
         diff = now - start;
         return diff >= span;
      endfunction

      function void close_window(input bit verified);
         session_flag = 0;
         mode = verified ? MODE_CODE_OPER : MODE_CODE_AWAIT;
      endfunction

      function void note_request(input req_payload_type r);
         rsp_payload_type status;
         bit              in_window;
         bit              granted;
         in_window = (mode == MODE_CODE_WINDOW);
         granted = 0;
         case (r.kind)
            KIND_BOOT: begin
               creds_flag = r.indicator;
               owner_flag = r.has_owner;
               pending_flag = 0;
               session_flag = 0;
               mode = r.indicator ? MODE_CODE_OPER : MODE_CODE_AWAIT;
               granted = 1;
            end
            KIND_BEGIN: begin
               if ((mode == MODE_CODE_AWAIT || mode == MODE_CODE_OPER
                    || mode == MODE_CODE_OFFLINE)
                   && !(cooldown_until != 0 && before_deadline(r.now_ms, cooldown_until))) begin
                  window_start = r.now_ms;
                  fail_count = '0;
                  pending_flag = 0;
                  session_flag = 0;
                  mode = MODE_CODE_WINDOW;
                  granted = 1;
               end
            end
            KIND_AUTH: begin
               if (in_window) begin
                  session_flag = 1;
                  granted = 1;
               end
            end
            KIND_ENROLL: begin
               if (in_window && session_flag && !owner_flag) begin
                  owner_flag = 1;
                  granted = 1;
               end
            end
            KIND_SUBMIT: begin
               if (in_window && session_flag && owner_flag
                   && r.ssid_present && r.ssid_length != 0
                   && r.ssid_length <= cfg.max_ssid_bytes
                   && r.pass_present && r.pass_length >= cfg.min_pass_bytes
                   && r.pass_length <= cfg.max_pass_bytes) begin
                  pending_flag = 1;
                  mode = MODE_CODE_PENDING;
                  granted = 1;
               end
            end
            KIND_USABLE: begin
               if (mode == MODE_CODE_PENDING && pending_flag) begin
                  handover_start = r.now_ms;
                  mode = MODE_CODE_HANDOVER;
                  granted = 1;
               end
            end
            KIND_CONFIRM: begin
               if (mode == MODE_CODE_HANDOVER && !before_deadline(r.now_ms, handover_start)
                   && !elapsed(r.now_ms, handover_start, cfg.handover_duration_ms)) begin
                  mode = MODE_CODE_PROMOTE;
                  granted = 1;
               end
            end
            KIND_PROMOTE: begin
               if (mode == MODE_CODE_PROMOTE && pending_flag) begin
                  creds_flag = 1;
                  pending_flag = 0;
                  session_flag = 0;
                  mode = MODE_CODE_OPER;
                  granted = 1;
               end
            end
            KIND_FAIL: begin
               if (in_window) begin
                  // With a limit of zero the count stays put and the first failure locks out.
                  if (fail_count < cfg.max_auth_failures) fail_count = fail_count + 8'd1;
                  if (fail_count >= cfg.max_auth_failures) begin
                     cooldown_until = r.now_ms + cfg.cooldown_duration_ms;
                     close_window(creds_flag);
                  end
                  granted = 1;
               end
            end
            KIND_AUTHORIZE: granted = in_window && session_flag && owner_flag && r.indicator;
            KIND_CLOSE: begin
               pending_flag = 0;
               close_window(r.indicator && creds_flag);
               granted = 1;
            end
            KIND_TICK: begin
               if ((in_window || mode == MODE_CODE_PENDING || mode == MODE_CODE_HANDOVER)
                   && (elapsed(r.now_ms, window_start, cfg.window_duration_ms)
                       || (mode == MODE_CODE_HANDOVER
                           && elapsed(r.now_ms, handover_start, cfg.handover_duration_ms))))
               begin
                  pending_flag = 0;
                  close_window(creds_flag);
               end
               granted = 1;
            end
            default: ;
         endcase
         status.accepted = granted;
         status.mode = mode;
         status.session_ok = (mode == MODE_CODE_WINDOW) && session_flag;
         status.owner_is_bound = owner_flag;
         status.creds_active = creds_flag;
         status.failure_total = fail_count;
         expected_status_q.push_back(status);
      endfunction

      function void report_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_status(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_status_q.size() == 0) begin
            errors++;
            $display("%0t: response %h arrived with no request outstanding", $time, got);
            return;
         end
         want = expected_status_q.pop_front();
         report_field("accepted", 32'(want.accepted), 32'(got.accepted));
         report_field("mode", 32'(want.mode), 32'(got.mode));
         report_field("session_ok", 32'(want.session_ok), 32'(got.session_ok));
         report_field("owner_is_bound", 32'(want.owner_is_bound), 32'(got.owner_is_bound));
         report_field("creds_active", 32'(want.creds_active), 32'(got.creds_active));
         report_field("failure_total", 32'(want.failure_total), 32'(got.failure_total));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   pwf_req_if req_if();
   pwf_rsp_if rsp_if();

   provisioning_window_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   window_status_board board;
   cfg_type            cur_cfg;
   logic [31:0]        now_stamp;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 stall_request = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;
   int                 sent_count = 0;
   logic [3:0]         flow_kinds [0:FLOW_LENGTH-1] = '{KIND_BOOT, KIND_BEGIN, KIND_AUTH,
      KIND_ENROLL, KIND_AUTHORIZE, KIND_SUBMIT, KIND_USABLE, KIND_CONFIRM, KIND_PROMOTE};

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: random back-pressure, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) board.note_request(req_if.data);
         if (rsp_if.valid && rsp_if.ready) board.check_status(rsp_if.data);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input req_payload_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic send_event(input logic [3:0] kind, input logic [31:0] now,
                             input bit ind = 0, input bit own = 0,
                             input bit sp = 0, input logic [7:0] sl = 8'd0,
                             input bit pp = 0, input logic [7:0] pl = 8'd0);
      req_payload_type r;
      r.kind = kind;
      r.now_ms = now;
      r.indicator = ind;
      r.has_owner = own;
      r.ssid_present = sp;
      r.ssid_length = sl;
      r.pass_present = pp;
      r.pass_length = pl;
      send_request(r);
   endtask

   // Wait until every response is back; the extra edge lets the last request be noted.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   task automatic apply_config(input cfg_type c);
      write_csr(CSR_WINDOW_DURATION, c.window_duration_ms);
      write_csr(CSR_HANDOVER_DURATION, c.handover_duration_ms);
      write_csr(CSR_COOLDOWN_DURATION, c.cooldown_duration_ms);
      write_csr(CSR_MAX_AUTH_FAILURES, {24'd0, c.max_auth_failures});
      write_csr(CSR_MAX_SSID_BYTES, {24'd0, c.max_ssid_bytes});
      write_csr(CSR_MIN_PASS_BYTES, {24'd0, c.min_pass_bytes});
      write_csr(CSR_MAX_PASS_BYTES, {24'd0, c.max_pass_bytes});
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   // Mostly short steps, with some landing right at a timeout boundary and some anywhere.
   function automatic logic [31:0] next_delta();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return $urandom_range(0, 40);
      if (pick < 68) return cur_cfg.handover_duration_ms + $urandom_range(0, 2) - 1;
      if (pick < 80) return cur_cfg.window_duration_ms + $urandom_range(0, 2) - 1;
      if (pick < 92) return $urandom();
      return 32'd0;
   endfunction

   function automatic req_payload_type random_event();
      req_payload_type r;
      now_stamp = now_stamp + next_delta();
      r.kind = 4'($urandom_range(0, 15));
      r.now_ms = now_stamp;
      r.indicator = 1'($urandom_range(0, 1));
      r.has_owner = 1'($urandom_range(0, 1));
      r.ssid_present = 1'($urandom_range(0, 1));
      r.ssid_length = 8'($urandom_range(0, 255));
      r.pass_present = 1'($urandom_range(0, 1));
      r.pass_length = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // One provisioning session from boot to promotion, with stray requests,
   // authentication failures and skipped steps mixed in.
   task automatic run_flow();
      req_payload_type r;
      for (int i = 0; i < FLOW_LENGTH; i++) begin
         if ($urandom_range(0, 99) < 10) send_request(random_event());
         if (i >= 2 && $urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 3)) begin
               r = random_event();
               r.kind = KIND_FAIL;
               send_request(r);
            end
         end
         if ($urandom_range(0, 99) >= 5) begin
            r = random_event();
            r.kind = flow_kinds[i];
            case (flow_kinds[i])
               KIND_BOOT: r.has_owner = ($urandom_range(0, 3) == 0);
               KIND_AUTHORIZE: r.indicator = ($urandom_range(0, 3) != 0);
               KIND_SUBMIT: begin
                  if ($urandom_range(0, 99) < 85) begin
                     r.ssid_present = 1'b1;
                     r.ssid_length = 8'($urandom_range(1, cur_cfg.max_ssid_bytes));
                     r.pass_present = 1'b1;
                     if (cur_cfg.min_pass_bytes <= cur_cfg.max_pass_bytes)
                        r.pass_length = 8'($urandom_range(cur_cfg.min_pass_bytes,
                                                          cur_cfg.max_pass_bytes));
                  end
               end
               default: ;
            endcase
            send_request(r);
         end
      end
      r = random_event();
      r.kind = $urandom_range(0, 1) ? KIND_TICK : KIND_CLOSE;
      send_request(r);
   endtask

   initial begin
      cfg_type c;
      int      target;
      board = new();
      cur_cfg = board.cfg;
      now_stamp = $urandom();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_WINDOW_DURATION;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      send_idle_pct = 8;
      recv_idle_pct = 58;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through one full session under the reset settings.
      send_event(KIND_BOOT, 32'd0);
      send_event(KIND_UNKNOWN_LO, 32'd5);
      send_event(KIND_UNKNOWN_HI, 32'hFFFF_FFFF, 1, 1, 1, 8'hFF, 1, 8'hFF);
      send_event(KIND_BEGIN, 32'd100);
      send_event(KIND_SUBMIT, 32'd105, 0, 0, 1, 8'd8, 1, 8'd12);
      send_event(KIND_AUTH, 32'd110);
      send_event(KIND_AUTHORIZE, 32'd115, 1);
      send_event(KIND_ENROLL, 32'd120);
      send_event(KIND_AUTHORIZE, 32'd125, 1);
      send_event(KIND_SUBMIT, 32'd130, 0, 0, 1, 8'd0, 1, 8'd12);
      send_event(KIND_SUBMIT, 32'd131, 0, 0, 1, 8'd33, 1, 8'd12);
      send_event(KIND_SUBMIT, 32'd132, 0, 0, 1, 8'd32, 1, 8'd7);
      send_event(KIND_SUBMIT, 32'd133, 0, 0, 1, 8'd32, 1, 8'd63);
      send_event(KIND_USABLE, 32'd200);
      send_event(KIND_CONFIRM, 32'd199);
      send_event(KIND_CONFIRM, 32'd30200);
      send_event(KIND_CONFIRM, 32'd30199);
      send_event(KIND_PROMOTE, 32'd30300);
      // A lockout whose end wraps to exactly zero must not block the next activation.
      send_event(KIND_BEGIN, 32'hFFFF_15A0);
      repeat (5) send_event(KIND_FAIL, 32'hFFFF_15A0);
      send_event(KIND_BEGIN, 32'hFFFF_15A0);
      send_event(KIND_TICK, 32'hFFFF_15A0 + 32'd300000);
      send_event(KIND_BOOT, 32'hFFFF_FFFF, 1, 1);
      send_event(KIND_CLOSE, 32'd0, 1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         case (phase)
            0: c = '{32'd300000, 32'd30000, 32'd60000, 8'd5, 8'd32, 8'd8, 8'd63};
            1: c = '{32'd4000, 32'd800, 32'd2500, 8'd3, 8'd16, 8'd4, 8'd20};
            2: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd0,
                     8'd255};
            3: c = '{32'd0, 32'd1, 32'd0, 8'd0, 8'd1, 8'd0, 8'd0};
            4: c = '{32'd1, 32'd0, 32'd1, 8'd1, 8'd255, 8'd255, 8'd255};
            default: begin
               c.window_duration_ms = $urandom_range(1000, 400000);
               c.handover_duration_ms = $urandom_range(1, 20000);
               c.cooldown_duration_ms = $urandom();
               c.max_auth_failures = 8'($urandom_range(1, 8));
               c.max_ssid_bytes = 8'($urandom_range(1, 255));
               c.min_pass_bytes = 8'($urandom_range(0, 40));
               c.max_pass_bytes = 8'($urandom_range(c.min_pass_bytes, 255));
            end
         endcase
         apply_config(c);
         if (phase < 2) begin
            send_idle_pct = 8;
            recv_idle_pct = 58;
         end else if (phase < 4) begin
            send_idle_pct = 58;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Starve the response side so the block fills and stops taking requests.
         if (phase == 0 || phase == 4) stall_request = 160;
         target = sent_count + ITEMS_PER_PHASE;
         while (sent_count < target) run_flow();
      end

      drain();
      repeat (4) @(posedge clock);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/pwf_pkg.sv
sv/pwf_if.sv
sv/pwf_csr.sv
sv/pwf_core.sv
sv/provisioning_window_fsm.sv
dv/testbench.sv
